### design/wpqs_pkg.sv
// Shared types and constants for the weighted priority queue selector.
package wpqs_pkg;

	localparam int unsigned CfgBits     = 4;
	localparam int unsigned PrioBits    = 8;
	localparam int unsigned StatusBits  = 2;
	localparam int unsigned QidxBits    = 3;
	localparam int unsigned TagFieldBits = 16;
	localparam int unsigned CntBits     = 5;
	localparam int unsigned RescaleAt   = 16;
	localparam int unsigned RescaleShift = 4;
	localparam logic [CfgBits-1:0] QueuesReset = 4'd2;

	// Operation codes carried in func.
	localparam logic FuncEnq   = 1'b0;
	localparam logic FuncServe = 1'b1;

	typedef enum logic [StatusBits-1:0] {
		ST_ENQUEUED = 2'd0,
		ST_DROPPED  = 2'd1,
		ST_SERVED   = 2'd2,
		ST_NONE     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_WRITE,
		S_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;      // capture input item
		logic scan_init; // reset the scan pointer
		logic scan_step; // evaluate one queue and advance
		logic rd;        // launch tag store read / decide enqueue
		logic commit;    // update queue state and form the result
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic is_serve;
		logic scan_done;
	} dp_sts_t;

endpackage

### design/wpqs_datapath.sv
// Queue storage, counters and the per-queue eligibility scan.
module wpqs_datapath #(
	parameter int unsigned MAX_QUEUES  = 8,
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_BITS    = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [wpqs_pkg::CfgBits-1:0]      cfg_q,
	input  wpqs_pkg::dp_cmd_t                 cmd,
	output wpqs_pkg::dp_sts_t                 sts,
	input  logic                              in_func,
	input  logic [wpqs_pkg::PrioBits-1:0]     in_prio,
	input  logic [wpqs_pkg::TagFieldBits-1:0] in_tag,
	output logic [wpqs_pkg::StatusBits-1:0]   res_status,
	output logic [wpqs_pkg::QidxBits-1:0]     res_qidx,
	output logic [wpqs_pkg::TagFieldBits-1:0] res_tag
);
	localparam int unsigned QB = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
	localparam int unsigned NB = $clog2(MAX_QUEUES + 1);
	localparam int unsigned DB = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned OB = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned WB = DB + 1; // head plus fill count
	localparam int unsigned CB = wpqs_pkg::CntBits;
	localparam int unsigned SB = CB + NB; // sum of counters
	localparam int unsigned Entries = MAX_QUEUES * QUEUE_DEPTH;
	localparam int unsigned AB = $clog2(Entries);

	logic [TAG_BITS-1:0] mem [Entries];
	logic [DB-1:0] head_q [MAX_QUEUES];
	logic [OB-1:0] occ_q  [MAX_QUEUES];
	logic [CB-1:0] cnt_q  [MAX_QUEUES];

	logic                func_q;
	logic [QB-1:0]       q_sel_q;
	logic                found_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [TAG_BITS-1:0] rd_q;
	logic                full_q;
	logic [QB-1:0]       scan_q;   // walks from the top queue downward
	logic [SB-1:0]       sum_q;
	logic                any_q;
	logic [NB-1:0]       n_act;
	logic [QB-1:0]       last_q;
	logic [QB-1:0]       enq_q;
	logic                elig;
	logic [WB-1:0]       slot_sum;
	logic [DB-1:0]       slot;
	logic [DB-1:0]       head_nxt;
	logic [AB-1:0]       base;
	logic [AB-1:0]       rd_addr;
	logic [AB-1:0]       wr_addr;
	logic                rescale;

	// Clamp the active count to 1..MAX_QUEUES.
	always_comb begin
		if (cfg_q == '0)
			n_act = NB'(1);
		else if ({{(32-wpqs_pkg::CfgBits){1'b0}}, cfg_q} > MAX_QUEUES)
			n_act = NB'(MAX_QUEUES);
		else
			n_act = NB'(cfg_q);
		last_q = QB'(n_act - NB'(1));
		if ({{(32-wpqs_pkg::PrioBits){1'b0}}, in_prio} >= 32'(n_act))
			enq_q = last_q;
		else
			enq_q = QB'(in_prio);
	end

	assign elig = (SB'(cnt_q[scan_q]) <= sum_q) || !any_q || (scan_q == last_q);
	// Wrap the tail slot and the head with a compare instead of a remainder.
	assign slot_sum = WB'(head_q[q_sel_q]) + WB'(occ_q[q_sel_q]);
	assign slot = (slot_sum >= WB'(QUEUE_DEPTH)) ? DB'(slot_sum - WB'(QUEUE_DEPTH)) :
		DB'(slot_sum);
	assign head_nxt = (head_q[q_sel_q] == DB'(QUEUE_DEPTH - 1)) ? '0 :
		head_q[q_sel_q] + DB'(1);
	assign base = AB'(q_sel_q) * AB'(QUEUE_DEPTH);
	assign rd_addr = base + AB'(head_q[q_sel_q]);
	assign wr_addr = base + AB'(slot);
	assign rescale = (cnt_q[q_sel_q] == CB'(wpqs_pkg::RescaleAt - 1));
	assign sts.is_serve = (func_q == wpqs_pkg::FuncServe);
	assign sts.scan_done = (scan_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= in_func;
			tag_q   <= TAG_BITS'(in_tag);
		end
		if (cmd.rd) begin
			rd_q   <= mem[rd_addr];
			full_q <= (occ_q[q_sel_q] == OB'(QUEUE_DEPTH));
			if (func_q == wpqs_pkg::FuncEnq && occ_q[q_sel_q] != OB'(QUEUE_DEPTH))
				mem[wr_addr] <= tag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_sel_q <= '0;
			scan_q  <= '0;
			sum_q   <= '0;
			any_q   <= 1'b0;
			found_q <= 1'b0;
			res_status <= '0;
			res_qidx   <= '0;
			res_tag    <= '0;
			for (int i = 0; i < MAX_QUEUES; i++) begin
				head_q[i] <= '0;
				occ_q[i]  <= '0;
				cnt_q[i]  <= '0;
			end
		end else begin
			if (cmd.load)
				q_sel_q <= enq_q;
			if (cmd.scan_init) begin
				scan_q  <= last_q;
				sum_q   <= '0;
				any_q   <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				// The lowest eligible non-empty queue wins, so later hits overwrite.
				if (occ_q[scan_q] != '0) begin
					if (elig) begin
						found_q <= 1'b1;
						q_sel_q <= scan_q;
					end
					sum_q <= sum_q + SB'(cnt_q[scan_q]);
					any_q <= 1'b1;
				end
				if (scan_q != '0)
					scan_q <= scan_q - QB'(1);
			end
			if (cmd.commit) begin
				res_qidx <= wpqs_pkg::QidxBits'({{wpqs_pkg::QidxBits{1'b0}}, q_sel_q});
				res_tag  <= '0;
				if (func_q == wpqs_pkg::FuncEnq) begin
					if (full_q)
						res_status <= wpqs_pkg::ST_DROPPED;
					else begin
						res_status <= wpqs_pkg::ST_ENQUEUED;
						occ_q[q_sel_q] <= occ_q[q_sel_q] + OB'(1);
					end
				end else if (!found_q) begin
					res_status <= wpqs_pkg::ST_NONE;
					res_qidx   <= '0;
				end else begin
					res_status <= wpqs_pkg::ST_SERVED;
					res_tag    <= wpqs_pkg::TagFieldBits'(rd_q);
					head_q[q_sel_q] <= head_nxt;
					occ_q[q_sel_q]  <= occ_q[q_sel_q] - OB'(1);
					if (rescale) begin
						for (int i = 0; i < MAX_QUEUES; i++)
							cnt_q[i] <= (QB'(i) == q_sel_q) ? CB'(1) :
								(cnt_q[i] >> wpqs_pkg::RescaleShift);
					end else
						cnt_q[q_sel_q] <= cnt_q[q_sel_q] + CB'(1);
				end
			end
		end
	end
endmodule

### design/wpqs_ctrl.sv
// Controller state machine sequencing load, scan, read and commit.
module wpqs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	input  wpqs_pkg::dp_sts_t sts,
	output wpqs_pkg::dp_cmd_t cmd,
	output logic              in_rdy,
	output logic              out_vld
);
	wpqs_pkg::state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wpqs_pkg::S_IDLE:  if (in_fire) state_d = wpqs_pkg::S_SCAN;
			wpqs_pkg::S_SCAN:  if (!sts.is_serve || sts.scan_done) state_d = wpqs_pkg::S_READ;
			wpqs_pkg::S_READ:  state_d = wpqs_pkg::S_WRITE;
			wpqs_pkg::S_WRITE: state_d = wpqs_pkg::S_OUT;
			wpqs_pkg::S_OUT:   if (out_fire) state_d = wpqs_pkg::S_IDLE;
			default:           state_d = wpqs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_rdy = 1'b0;
		out_vld = 1'b0;
		unique case (state_q)
			wpqs_pkg::S_IDLE: begin
				in_rdy = 1'b1;
				cmd.load = in_fire;
				cmd.scan_init = in_fire;
			end
			wpqs_pkg::S_SCAN:  cmd.scan_step = sts.is_serve;
			wpqs_pkg::S_READ:  cmd.rd = 1'b1;
			wpqs_pkg::S_WRITE: cmd.commit = 1'b1;
			wpqs_pkg::S_OUT:   out_vld = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= wpqs_pkg::S_IDLE;
		else
			state_q <= state_d;
	end
endmodule

### design/weighted_priority_queue_selector_unit.sv
// Top level of the weighted priority queue selector.
// Input stream s_axis: tdata carries func, priority_req and tag; one item per transfer.
// func 0 enqueues tag into the queue named by priority_req (clamped to the last
// active queue); func 1 serves one queue by weighted eligibility.
// Output stream m_axis: one result per item: status, queue_index, served_tag.
// An enqueue passes from the transfer through the scan, read and write states to
// result valid; a serve also runs the one-queue-per-cycle eligibility scan over the
// active queues (queues_in_use clamped to 1..MAX_QUEUES) in the scan state.
// One item is in flight at a time; the next can be taken in the cycle after
// the result transfers.
// cfg_we/cfg_wdata write queues_in_use; write only while idle.
// Reset clears heads, fill counts, service counters and sets queues_in_use to 2;
// tag storage is not cleared.
// A stalled m_axis_tready holds the result and blocks new input.
module weighted_priority_queue_selector_unit #(
	parameter int unsigned MAX_QUEUES  = 8,
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned TAG_BITS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // func[0], priority_req[8:1], tag[24:9]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // status[1:0], queue_index[4:2], served_tag[20:5]
);
	logic [wpqs_pkg::CfgBits-1:0] cfg_q;
	wpqs_pkg::dp_cmd_t cmd;
	wpqs_pkg::dp_sts_t sts;
	logic [1:0]  r_status;
	logic [2:0]  r_qidx;
	logic [15:0] r_tag;
	logic in_fire, out_fire;

	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata = {3'b000, r_tag, r_qidx, r_status};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= wpqs_pkg::QueuesReset;
		else if (cfg_we)
			cfg_q <= cfg_wdata;
	end

	wpqs_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .out_fire, .sts, .cmd,
		.in_rdy(s_axis_tready), .out_vld(m_axis_tvalid)
	);

	wpqs_datapath #(
		.MAX_QUEUES(MAX_QUEUES), .QUEUE_DEPTH(QUEUE_DEPTH), .TAG_BITS(TAG_BITS)
	) u_dp (
		.clk, .arst_n, .cfg_q, .cmd, .sts,
		.in_func(s_axis_tdata[0]), .in_prio(s_axis_tdata[8:1]),
		.in_tag(s_axis_tdata[24:9]),
		.res_status(r_status), .res_qidx(r_qidx), .res_tag(r_tag)
	);

`ifndef SYNTH
	// No new item while a result is pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("input open with result pending");
	// An item's result must not show up too soon after the item is taken.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !m_axis_tvalid ##1 !m_axis_tvalid) else $error("result too early");
	// Non-served results carry no tag.
	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && r_status != wpqs_pkg::ST_SERVED) |-> (r_tag == '0))
		else $error("tag on non-serve result");
`endif
endmodule
